[design/lattice_site_particle_store_top_defines.svh]
// ----------------------------------------------------------------------------
// Lattice site particle store: assertion macros
// Shared assertion wrappers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef LATTICE_SITE_PARTICLE_STORE_TOP_DEFINES_SVH
`define LATTICE_SITE_PARTICLE_STORE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define LSPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define LSPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSPS_ASSERT(lbl, prop, msg)
`define LSPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/lsps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice site particle store: package
// Sizes, action and status codes, and the word types shared by all modules.
// ----------------------------------------------------------------------------
package lsps_pkg;

	localparam int MAX_SITES          = 4096;
	localparam int MAX_WORDS_PER_SITE = 4;
	localparam int SLOTS_PER_WORD     = 4;

	localparam int SLOTS_PER_SITE = MAX_WORDS_PER_SITE * SLOTS_PER_WORD;
	localparam int ROW_W          = SLOTS_PER_SITE * 8;
	localparam int SITE_W         = $clog2(MAX_SITES);
	localparam int SITE_CNT_W     = SITE_W + 1;
	localparam int CAP_W          = $clog2(SLOTS_PER_SITE + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [7:0] EMPTY_SLOT = 8'hFF;

	// Action codes.
	localparam logic [2:0] ACT_ADD        = 3'd0;
	localparam logic [2:0] ACT_CLEAR_SITE = 3'd1;
	localparam logic [2:0] ACT_READ_SLOT  = 3'd2;
	localparam logic [2:0] ACT_READ_OCC   = 3'd3;
	localparam logic [2:0] ACT_WRITE_TYPE = 3'd4;
	localparam logic [2:0] ACT_READ_TYPE  = 3'd5;
	localparam logic [2:0] ACT_CLEAR_ALL  = 3'd6;
	localparam logic [2:0] ACT_RESERVED   = 3'd7;

	// Status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SITE = 2'd1;
	localparam logic [1:0] ST_BAD_SLOT = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_SIZE_X     = 3'd0;
	localparam logic [2:0] CFG_SIZE_Y     = 3'd1;
	localparam logic [2:0] CFG_SIZE_Z     = 3'd2;
	localparam logic [2:0] CFG_SITE_COUNT = 3'd3;
	localparam logic [2:0] CFG_WORDS      = 3'd4;

	typedef logic [SITE_W-1:0]     site_t;
	typedef logic [SITE_CNT_W-1:0] site_cnt_t;
	typedef logic [CAP_W-1:0]      cap_t;
	typedef logic [ROW_W-1:0]      row_t;

	typedef struct packed {
		logic [2:0]  action;
		logic        use_linear;
		logic [11:0] coord_x;
		logic [11:0] coord_y;
		logic [11:0] coord_z;
		logic [11:0] site_index;
		logic [3:0]  slot_index;
		logic [7:0]  value;
	} item_t;

	typedef struct packed {
		logic [7:0] read_value;
		logic [4:0] occupancy;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic [12:0] size_x;
		logic [12:0] size_y;
		logic [12:0] size_z;
		logic [12:0] site_count;
		logic [2:0]  words_per_site;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		size_x:         13'd16,
		size_y:         13'd16,
		size_z:         13'd16,
		site_count:     13'd4096,
		words_per_site: 3'd1
	};

	// Classified command passed from the front end to the back end.
	typedef struct packed {
		logic [2:0] action;
		logic       site_ok;
		site_t      site;
		logic [3:0] slot_index;
		logic [7:0] value;
	} cmd_t;

endpackage

[design/lsps_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice site particle store: front end
// Three-stage pipeline that linearizes the site address and checks it.
// ----------------------------------------------------------------------------
module lsps_front (
	input  logic             clk,
	input  logic             arst_n,
	input  lsps_pkg::cfg_t   cfg,
	input  logic             item_valid,
	output logic             item_stall,
	input  lsps_pkg::item_t  item,
	input  logic             hold,
	output logic             cmd_push,
	output lsps_pkg::cmd_t   cmd,
	input  logic             queue_full
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	lsps_pkg::item_t item_s1, item_s2, item_s3;
	logic [24:0] ysx_s2, ysx_s3;
	lsps_pkg::site_cnt_t sxy_sat_s2;
	logic [24:0] zsxy_s3;
	logic coord_ok_s2, coord_ok_s3;
	logic lin_ok_s2, lin_ok_s3;

	logic [24:0] ysx;
	logic [25:0] sxy;
	lsps_pkg::site_cnt_t sxy_sat;
	logic coord_ok, lin_ok;
	logic [24:0] zsxy;
	logic [26:0] lin;

	// Stall chain: a stage loads when it is empty or moving on.
	assign cmd_push   = v_s3 && !queue_full;
	assign en_s3      = !v_s3 || cmd_push;
	assign en_s2      = !v_s2 || en_s3;
	assign en_s1      = !v_s1 || en_s2;
	assign item_stall = !en_s1 || hold;

	// Stage 1: the row offset, the plane size and the coordinate and index checks.
	assign ysx = 25'(item_s1.coord_y) * 25'(cfg.size_x);
	assign sxy = 26'(cfg.size_x) * 26'(cfg.size_y);
	// Any plane bigger than the store makes every z above zero invalid anyway.
	assign sxy_sat = (sxy > 26'(lsps_pkg::MAX_SITES)) ?
		lsps_pkg::site_cnt_t'(lsps_pkg::MAX_SITES) : lsps_pkg::site_cnt_t'(sxy);
	assign coord_ok = (13'(item_s1.coord_x) < cfg.size_x) &&
		(13'(item_s1.coord_y) < cfg.size_y) && (13'(item_s1.coord_z) < cfg.size_z);
	assign lin_ok = (13'(item_s1.site_index) < cfg.site_count) &&
		(32'(item_s1.site_index) < 32'(lsps_pkg::MAX_SITES));

	// Stage 2: the plane offset.
	assign zsxy = 25'(item_s2.coord_z) * 25'(sxy_sat_s2);

	// Stage 3: sum and range check.
	assign lin = 27'(item_s3.coord_x) + 27'(ysx_s3) + 27'(zsxy_s3);

	always_comb begin
		cmd.action     = item_s3.action;
		cmd.slot_index = item_s3.slot_index;
		cmd.value      = item_s3.value;
		if (item_s3.use_linear) begin
			cmd.site_ok = lin_ok_s3;
			cmd.site    = lsps_pkg::site_t'(item_s3.site_index);
		end else begin
			cmd.site_ok = coord_ok_s3 && (32'(lin) < 32'(lsps_pkg::MAX_SITES));
			cmd.site    = lin[lsps_pkg::SITE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= item_valid && !hold;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= item;
		end
		if (en_s2) begin
			item_s2     <= item_s1;
			ysx_s2      <= ysx;
			sxy_sat_s2  <= sxy_sat;
			coord_ok_s2 <= coord_ok;
			lin_ok_s2   <= lin_ok;
		end
		if (en_s3) begin
			item_s3     <= item_s2;
			ysx_s3      <= ysx_s2;
			zsxy_s3     <= zsxy;
			coord_ok_s3 <= coord_ok_s2;
			lin_ok_s3   <= lin_ok_s2;
		end
	end

endmodule

[design/lsps_queue.sv]
`timescale 1ns / 1ps
`include "lattice_site_particle_store_top_defines.svh"
// ----------------------------------------------------------------------------
// Lattice site particle store: command queue
// Short queue of classified commands between the front end and the back end.
// ----------------------------------------------------------------------------
module lsps_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lsps_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output lsps_pkg::cmd_t  head
);

	lsps_pkg::cmd_t entry_q [lsps_pkg::QUEUE_DEPTH];
	logic [lsps_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lsps_pkg::QCNT_W-1:0] count_q;

	assign full      = (count_q == lsps_pkg::QCNT_W'(lsps_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	`LSPS_ASSERT(a_no_push_full, push |-> !full, "command pushed into a full queue")
	`LSPS_ASSERT(a_no_pop_empty, pop |-> (count_q != '0), "command popped from an empty queue")

endmodule

[design/lsps_back.sv]
`timescale 1ns / 1ps
`include "lattice_site_particle_store_top_defines.svh"
// ----------------------------------------------------------------------------
// Lattice site particle store: back end
// Slot and type memories, read-modify-write of one site, clearing sweeps.
// ----------------------------------------------------------------------------
module lsps_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         words_per_site,
	input  logic               cmd_avail,
	input  lsps_pkg::cmd_t     cmd,
	output logic               pop,
	output logic               init_busy,
	output logic               result_valid,
	input  logic               result_stall,
	output lsps_pkg::result_t  result
);

	typedef enum logic [1:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_SWEEP
	} state_t;

	state_t                 state_q;
	lsps_pkg::site_t        cnt_q;
	lsps_pkg::cmd_t         cmd_q;
	logic                   result_valid_q;
	lsps_pkg::result_t      result_q;

	lsps_pkg::row_t         slot_mem [lsps_pkg::MAX_SITES];
	logic [7:0]             type_mem [lsps_pkg::MAX_SITES];
	lsps_pkg::row_t         slot_rd_q;
	logic [7:0]             type_rd_q;

	logic                   slot_we, type_we;
	lsps_pkg::site_t        wr_addr;
	lsps_pkg::row_t         slot_wdata, row_new;
	logic [7:0]             type_wdata;
	lsps_pkg::result_t      res_exec;
	lsps_pkg::cap_t         cap, occ;
	logic                   found, site_action, out_free, load_res, sweep_last;
	logic [7:0]             sel_slot;

	assign out_free   = !result_valid_q || !result_stall;
	assign pop        = (state_q == S_IDLE) && cmd_avail && out_free;
	assign init_busy  = (state_q == S_INIT);
	assign sweep_last = (cnt_q == lsps_pkg::site_t'(lsps_pkg::MAX_SITES - 1));
	assign load_res   = ((state_q == S_EXEC) && (cmd_q.action != lsps_pkg::ACT_CLEAR_ALL)) ||
		((state_q == S_SWEEP) && sweep_last);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Capacity saturates at the row size.
	assign cap = (32'(words_per_site) > 32'(lsps_pkg::MAX_WORDS_PER_SITE)) ?
		lsps_pkg::cap_t'(lsps_pkg::SLOTS_PER_SITE) :
		lsps_pkg::cap_t'(32'(words_per_site) * 32'(lsps_pkg::SLOTS_PER_WORD));

	assign site_action = cmd_q.action inside {lsps_pkg::ACT_ADD, lsps_pkg::ACT_CLEAR_SITE,
		lsps_pkg::ACT_READ_SLOT, lsps_pkg::ACT_READ_OCC, lsps_pkg::ACT_WRITE_TYPE,
		lsps_pkg::ACT_READ_TYPE};

	always_comb begin
		row_new  = slot_rd_q;
		found    = 1'b0;
		sel_slot = '0;
		occ      = lsps_pkg::cap_t'(lsps_pkg::SLOTS_PER_SITE);
		res_exec = '0;

		// Occupancy stops at the first empty slot or at the capacity.
		for (int i = lsps_pkg::SLOTS_PER_SITE - 1; i >= 0; i--) begin
			if (!((lsps_pkg::cap_t'(i) < cap) && (slot_rd_q[i*8 +: 8] != lsps_pkg::EMPTY_SLOT)))
				occ = lsps_pkg::cap_t'(i);
		end
		for (int i = 0; i < lsps_pkg::SLOTS_PER_SITE; i++) begin
			if (32'(cmd_q.slot_index) == 32'(i)) sel_slot = slot_rd_q[i*8 +: 8];
		end

		case (cmd_q.action)
			lsps_pkg::ACT_ADD: begin
				for (int i = 0; i < lsps_pkg::SLOTS_PER_SITE; i++) begin
					if (!found && (lsps_pkg::cap_t'(i) < cap) &&
							(slot_rd_q[i*8 +: 8] == lsps_pkg::EMPTY_SLOT)) begin
						row_new[i*8 +: 8] = cmd_q.value;
						found = 1'b1;
					end
				end
				res_exec.status = found ? lsps_pkg::ST_OK : lsps_pkg::ST_FULL;
			end
			lsps_pkg::ACT_CLEAR_SITE: begin
				for (int i = 0; i < lsps_pkg::SLOTS_PER_SITE; i++) begin
					if (lsps_pkg::cap_t'(i) < cap) row_new[i*8 +: 8] = lsps_pkg::EMPTY_SLOT;
				end
			end
			lsps_pkg::ACT_READ_SLOT: begin
				if (lsps_pkg::cap_t'(cmd_q.slot_index) < cap) res_exec.read_value = sel_slot;
				else res_exec.status = lsps_pkg::ST_BAD_SLOT;
			end
			lsps_pkg::ACT_READ_OCC: begin
				res_exec.occupancy = 5'(occ);
			end
			lsps_pkg::ACT_READ_TYPE: begin
				res_exec.read_value = type_rd_q;
			end
			default: begin
			end
		endcase

		if (site_action && !cmd_q.site_ok) begin
			res_exec        = '0;
			res_exec.status = lsps_pkg::ST_BAD_SITE;
		end
	end

	// Memory write port: sweeps first, otherwise the write-back of the site.
	always_comb begin
		slot_we    = 1'b0;
		type_we    = 1'b0;
		wr_addr    = cnt_q;
		slot_wdata = {lsps_pkg::SLOTS_PER_SITE{lsps_pkg::EMPTY_SLOT}};
		type_wdata = '0;
		case (state_q)
			S_INIT: begin
				slot_we = 1'b1;
				type_we = 1'b1;
			end
			S_SWEEP: begin
				slot_we = 1'b1;
			end
			S_EXEC: begin
				wr_addr    = cmd_q.site;
				slot_wdata = row_new;
				type_wdata = cmd_q.value;
				slot_we    = cmd_q.site_ok && ((cmd_q.action == lsps_pkg::ACT_ADD && found) ||
					cmd_q.action == lsps_pkg::ACT_CLEAR_SITE);
				type_we    = cmd_q.site_ok && (cmd_q.action == lsps_pkg::ACT_WRITE_TYPE);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[wr_addr] <= slot_wdata;
		slot_rd_q <= slot_mem[cmd.site];
	end

	always_ff @(posedge clk) begin
		if (type_we) type_mem[wr_addr] <= type_wdata;
		type_rd_q <= type_mem[cmd.site];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_INIT;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) result_valid_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (sweep_last) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (pop) begin
						cmd_q   <= cmd;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd_q.action == lsps_pkg::ACT_CLEAR_ALL) begin
						cnt_q   <= '0;
						state_q <= S_SWEEP;
					end else begin
						result_q       <= res_exec;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (sweep_last) begin
						cnt_q          <= '0;
						result_q       <= '0;
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`LSPS_ASSERT(a_pop_to_exec, pop |=> (state_q == S_EXEC), "popped command did not start")
	`LSPS_ASSERT(a_out_empty_after_pop, pop |=> !result_valid_q, "output busy after a pop")
	`LSPS_ASSERT(a_load_when_free, load_res |-> out_free, "result loaded over a waiting one")
	`LSPS_ASSERT(a_no_write_idle, (state_q == S_IDLE) |-> !(slot_we || type_we),
		"memory written while idle")

endmodule

[design/lattice_site_particle_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lattice site particle store: top level
// A 3-D lattice of sites, each with a type byte and up to sixteen particle
// slots. Items enter on the item channel and results leave on the result
// channel, one result per item, in order. After reset the block runs a
// clearing pass over every site of the slot and type memories; item_stall
// stays high meanwhile, while configuration writes are taken as ever. Items then
// pass a three-stage address pipeline (linearization and range checks) into a
// four-deep command queue, so the front end keeps taking items while the back end
// works or the result waits. The back end reads a whole site row, modifies it and
// writes it back; it ends that read-modify-write on the slot memory before it pops
// the next command, and it pops only while the result register is free. A clear-all
// item sweeps the slot memory one site per cycle. An accepted item passes the
// address stages, the command queue and the execute state before its result word
// is registered. The configuration port is always ready; the user must ensure
// registers are written only while no item is in flight; the block does not check.
// ----------------------------------------------------------------------------
module lattice_site_particle_store_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lsps_pkg::item_t    item,
	output logic               result_valid,
	input  logic               result_stall,
	output lsps_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [12:0]        cfg_data
);

	lsps_pkg::cfg_t cfg_q;

	logic           cmd_push, queue_full, queue_not_empty, pop, init_busy;
	lsps_pkg::cmd_t cmd_in, cmd_head;

	// Writes go straight into the registers, so the port never pushes back.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lsps_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lsps_pkg::CFG_SIZE_X:     cfg_q.size_x         <= cfg_data;
				lsps_pkg::CFG_SIZE_Y:     cfg_q.size_y         <= cfg_data;
				lsps_pkg::CFG_SIZE_Z:     cfg_q.size_z         <= cfg_data;
				lsps_pkg::CFG_SITE_COUNT: cfg_q.site_count     <= cfg_data;
				lsps_pkg::CFG_WORDS:      cfg_q.words_per_site <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: address linearization and site checks.
	lsps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.hold       (init_busy),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.queue_full (queue_full)
	);

	// Decouples the two halves so each can stall on its own.
	lsps_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_cmd  (cmd_in),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.head      (cmd_head)
	);

	// Back end: memories, site read-modify-write and the result register.
	lsps_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.words_per_site (cfg_q.words_per_site),
		.cmd_avail      (queue_not_empty),
		.cmd            (cmd_head),
		.pop            (pop),
		.init_busy      (init_busy),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.result         (result)
	);

endmodule
